[rtl/core/utf8c_pkg.sv]
// ----------------------------------------------------------------------------
// utf8c_pkg
// Shared types, constants and the CP437 to UTF-8 encoding for the line
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8c_pkg;

    localparam int LINE_MAX  = 64;
    localparam int IDX_W     = $clog2(LINE_MAX);
    localparam int CNT_W     = $clog2(LINE_MAX + 1);
    localparam int TDATA_O_W = 40;

    // register byte addresses
    localparam logic [2:0] ADDR_ALLOW_FALLBACK = 3'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } state_t;

    typedef enum logic [1:0] {
        MODE_RAW,
        MODE_XLAT
    } mode_t;

    // checker control from the sequencer
    typedef struct packed {
        logic       store;
        logic [7:0] data;
        logic       clear;
    } chk_ctrl_t;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  len;
    } utf8_char_t;

    localparam logic [15:0] CP437_LO [32] = '{
        16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
        16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
    };

    localparam logic [15:0] CP437_HI [128] = '{
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    function automatic logic [15:0] cp437_cp(input logic [7:0] b);
        logic [15:0] cp;
        if (b[7])
            cp = CP437_HI[b[6:0]];
        else if (b < 8'h20)
            cp = CP437_LO[b[4:0]];
        else if (b == 8'h7F)
            cp = 16'h2302;
        else
            cp = {8'h00, b};
        return cp;
    endfunction

    function automatic utf8_char_t utf8_encode(input logic [15:0] cp);
        utf8_char_t c;
        if (cp <= 16'h007F) begin
            c.bytes = {16'h0000, cp};
            c.len   = 3'd1;
        end else if (cp <= 16'h07FF) begin
            c.bytes = {16'h0000, 2'b10, cp[5:0], 3'b110, cp[10:6]};
            c.len   = 3'd2;
        end else begin
            c.bytes = {8'h00, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
            c.len   = 3'd3;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/core/utf8c_checker.sv]
// ----------------------------------------------------------------------------
// utf8c_checker
// Running UTF-8 lead/continuation check over the bytes of one line.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8c_checker
    import utf8c_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire chk_ctrl_t ctrl,
    output logic           line_bad
);

    logic [1:0] pending_reg, pending_next;
    logic       invalid_reg, invalid_next;
    logic [1:0] pend_upd;
    logic       inv_upd;

    always_comb
    begin
        pend_upd = pending_reg;
        inv_upd  = invalid_reg;
        if (ctrl.store && !invalid_reg) begin
            if (pending_reg != 2'd0) begin
                if (ctrl.data[7:6] == 2'b10)
                    pend_upd = pending_reg - 2'd1;
                else
                    inv_upd = 1'b1;
            end else if (!ctrl.data[7]) begin
                pend_upd = 2'd0;
            end else if (ctrl.data[7:5] == 3'b110) begin
                pend_upd = 2'd1;
            end else if (ctrl.data[7:4] == 4'b1110) begin
                pend_upd = 2'd2;
            end else if (ctrl.data[7:3] == 5'b11110) begin
                pend_upd = 2'd3;
            end else begin
                inv_upd = 1'b1;
            end
        end
        // an open sequence at line end counts as invalid
        line_bad = inv_upd || (pend_upd != 2'd0);
        if (ctrl.clear) begin
            pending_next = 2'd0;
            invalid_next = 1'b0;
        end else begin
            pending_next = pend_upd;
            invalid_next = inv_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= 2'd0;
            invalid_reg <= 1'b0;
        end else begin
            pending_reg <= pending_next;
            invalid_reg <= invalid_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/utf8_check_cp437_fallback.sv]
// ----------------------------------------------------------------------------
// utf8_check_cp437_fallback
// Line buffer with UTF-8 check, emitting the line raw or via CP437.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one line byte per transfer in s_tdata[7:0], s_tuser is
//   byte present, s_tlast ends the line. Bytes are taken one per cycle.
//   Output stream m_*: one character per transfer; s_tready stays low from
//   the line-end transfer until the last result of that line is taken.
//   A valid line is output raw (one byte per result); an invalid one goes
//   through CP437 to UTF-8 when allow_fallback is set, else one error result.
//   An empty line gives one result of length zero.
//   After the line-end transfer each result passes the buffer read, the
//   encode and the output register in turn (empty and error lines go straight
//   to the output register); a further result is fetched only once the one
//   before is taken, and the result simply holds while the receiver stalls.
//   Up to 64 bytes are buffered; further bytes are dropped and line_overflow
//   is flagged on every result of that line.
//   Reset clears the sequencer and flags and sets allow_fallback to 1; the
//   line buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_check_cp437_fallback
    import utf8c_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input stream
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] line_byte
    input  wire logic                 s_tuser,   // [0] byte_present
    input  wire logic                 s_tlast,   // line_end
    // output stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_O_W-1:0]      m_tdata,   // [31:0] char_bytes, [34:32] char_len
    output logic [2:0]                m_tuser,   // [0] fallback_used, [1] line_error,
                                                 // [2] line_overflow
    output logic                      m_tlast,   // last_of_line
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    state_t           state_reg, state_next;
    mode_t            mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             ovf_reg, ovf_next;
    logic             allow_fb_reg, allow_fb_next;

    logic [7:0]       mem [LINE_MAX];
    logic [7:0]       rd_data_reg;

    logic [31:0]      o_bytes_reg, o_bytes_next;
    logic [2:0]       o_len_reg, o_len_next;
    logic             o_fb_reg, o_fb_next;
    logic             o_err_reg, o_err_next;
    logic             o_ovf_reg, o_ovf_next;
    logic             o_last_reg, o_last_next;

    logic             s_acc, m_acc, cfg_wr;
    logic             room, store_byte, line_bad, last_idx;
    chk_ctrl_t        chk_ctrl;
    utf8_char_t       enc;

    assign s_acc      = s_tvalid && s_tready;
    assign m_acc      = m_tvalid && m_tready;
    assign room       = (count_reg < CNT_W'(LINE_MAX));
    assign store_byte = s_acc && s_tuser && room;
    assign last_idx   = ({1'b0, idx_reg} + CNT_W'(1)) == count_reg;
    assign enc        = utf8_encode(cp437_cp(rd_data_reg));

    assign chk_ctrl.store = store_byte;
    assign chk_ctrl.data  = s_tdata;
    assign chk_ctrl.clear = s_acc && s_tlast;

    utf8c_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (chk_ctrl),
        .line_bad (line_bad)
    );

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_ALLOW_FALLBACK);
    assign allow_fb_next = cfg_wr ? pwdata[0] : allow_fb_reg;
    assign prdata = (paddr == ADDR_ALLOW_FALLBACK) ? {31'd0, allow_fb_reg} : 32'd0;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_acc && s_tlast) begin
                    if (count_next == CNT_W'(0) || (line_bad && !allow_fb_reg))
                        state_next = ST_SEND;
                    else
                        state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: state_next = ST_SEND;
            ST_SEND:
            begin
                if (m_acc)
                    state_next = o_last_reg ? ST_IDLE : ST_READ;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        ovf_next     = ovf_reg;
        mode_next    = mode_reg;
        o_bytes_next = o_bytes_reg;
        o_len_next   = o_len_reg;
        o_fb_next    = o_fb_reg;
        o_err_next   = o_err_reg;
        o_ovf_next   = o_ovf_reg;
        o_last_next  = o_last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (store_byte)
                    count_next = count_reg + CNT_W'(1);
                if (s_acc && s_tuser && !room)
                    ovf_next = 1'b1;
                if (s_acc && s_tlast) begin
                    idx_next     = '0;
                    mode_next    = line_bad ? MODE_XLAT : MODE_RAW;
                    o_bytes_next = 32'd0;
                    o_len_next   = 3'd0;
                    o_fb_next    = 1'b0;
                    o_err_next   = (count_next != CNT_W'(0)) && line_bad;
                    o_ovf_next   = ovf_next;
                    o_last_next  = 1'b1;
                end
            end
            ST_READ: ;
            ST_LOAD:
            begin
                o_err_next  = 1'b0;
                o_ovf_next  = ovf_reg;
                o_last_next = last_idx;
                if (mode_reg == MODE_XLAT) begin
                    o_bytes_next = enc.bytes;
                    o_len_next   = enc.len;
                    o_fb_next    = 1'b1;
                end else begin
                    o_bytes_next = {24'd0, rd_data_reg};
                    o_len_next   = 3'd1;
                    o_fb_next    = 1'b0;
                end
            end
            ST_SEND:
            begin
                if (m_acc) begin
                    if (o_last_reg) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_SEND);
    assign m_tdata  = {5'd0, o_len_reg, o_bytes_reg};
    assign m_tuser  = {o_ovf_reg, o_err_reg, o_fb_reg};
    assign m_tlast  = o_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_RAW;
            count_reg    <= '0;
            idx_reg      <= '0;
            ovf_reg      <= 1'b0;
            allow_fb_reg <= 1'b1;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            ovf_reg      <= ovf_next;
            allow_fb_reg <= allow_fb_next;
        end
    end

    // line buffer
    always_ff @(posedge clk)
    begin
        if (store_byte)
            mem[count_reg[IDX_W-1:0]] <= s_tdata;
        rd_data_reg <= mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        o_bytes_reg <= o_bytes_next;
        o_len_reg   <= o_len_next;
        o_fb_reg    <= o_fb_next;
        o_err_reg   <= o_err_next;
        o_ovf_reg   <= o_ovf_next;
        o_last_reg  <= o_last_next;
    end

endmodule

`default_nettype wire

[rtl/core/utf8c_chk.sv]
// ----------------------------------------------------------------------------
// utf8c_chk
// Port-level checks for the line checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8c_chk
    import utf8c_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [TDATA_O_W-1:0] m_tdata,
    input wire logic [2:0]           m_tuser,
    input wire logic                 m_tlast
);

    // input is never taken while a result is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a result is shown");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0] && (m_tdata[34:32] == 3'd0))
        else $error("malformed error result");

    a_raw_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] && !m_tuser[1] && (m_tdata[34:32] != 3'd0)
        |-> (m_tdata[34:32] == 3'd1) && (m_tdata[31:8] == 24'd0))
        else $error("raw result not a single byte");

    a_back_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
        else $error("not back to input after line end");

endmodule

bind utf8_check_cp437_fallback utf8c_chk u_utf8c_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

[dv/tb_utf8_check_cp437_fallback.sv]
// ----------------------------------------------------------------------------
// tb_utf8_check_cp437_fallback
// Self-checking bench for the line UTF-8 checker with CP437 fallback. A
// directed table covers the edge cases; random lines (about half well-formed
// UTF-8, the rest cut short, corrupted or pure noise, two overflowing the buffer)
// follow with fallback off and on. Every output transfer is compared field
// by field against a line model kept in the bench or the directed table's
// expectation, with random stalls on both streams.
// ----------------------------------------------------------------------------
module tb_utf8_check_cp437_fallback;
    import utf8c_pkg::*;

    localparam int STUCK_LIMIT = 1000;

    typedef struct {
        logic [31:0] bytes;
        logic [2:0]  len;
        logic        fb;
        logic        err;
        logic        ovf;
        logic        last;
    } char_result_t;

    typedef enum logic {ROW_XFER, ROW_WRITE} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  data;
        logic        present;
        logic        last;
        logic        typed;
        logic [31:0] w_bytes;
        logic [2:0]  w_len;
        logic        w_fb;
        logic        w_err;
    } stim_row_t;

    // typed rows are single-result lines, so their expectation always ends the line
    localparam stim_row_t DIRECTED [24] = '{
        '{ROW_XFER,  8'hA5, 1'b0, 1'b1, 1'b1, 32'h0000_0000, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h00, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 3'd1, 1'b0, 1'b0},
        '{ROW_XFER,  8'h7F, 1'b1, 1'b1, 1'b1, 32'h0000_007F, 3'd1, 1'b0, 1'b0},
        '{ROW_XFER,  8'hFF, 1'b1, 1'b1, 1'b1, 32'h0000_A0C2, 3'd2, 1'b1, 1'b0},
        '{ROW_XFER,  8'h80, 1'b1, 1'b1, 1'b1, 32'h0000_87C3, 3'd2, 1'b1, 1'b0},
        '{ROW_XFER,  8'hE2, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h5A, 1'b0, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h82, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'hAC, 1'b1, 1'b1, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'hF0, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h9F, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h98, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h80, 1'b1, 1'b1, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'hC3, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h41, 1'b1, 1'b1, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h01, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h7F, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'hC0, 1'b1, 1'b1, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'hF8, 1'b1, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'h00, 1'b0, 1'b1, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 1'b0, 32'h0, 3'd0, 1'b0, 1'b0},
        '{ROW_XFER,  8'hFF, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 3'd0, 1'b0, 1'b1},
        '{ROW_XFER,  8'hC3, 1'b1, 1'b1, 1'b1, 32'h0000_0000, 3'd0, 1'b0, 1'b1},
        '{ROW_XFER,  8'h41, 1'b1, 1'b1, 1'b1, 32'h0000_0041, 3'd1, 1'b0, 1'b0}
    };

    localparam logic [15:0] CP437_UNI [256] = '{
        16'h0000, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
        16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
        16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
        16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC,
        16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h0024, 16'h0025, 16'h0026, 16'h0027,
        16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
        16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
        16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
        16'h0040, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
        16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
        16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
        16'h0058, 16'h0059, 16'h005A, 16'h005B, 16'h005C, 16'h005D, 16'h005E, 16'h005F,
        16'h0060, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
        16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
        16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
        16'h0078, 16'h0079, 16'h007A, 16'h007B, 16'h007C, 16'h007D, 16'h007E, 16'h2302,
        16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
        16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
        16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
        16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
        16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
        16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
        16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
        16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
        16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
        16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
        16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
        16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
        16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
        16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
        16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
        16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
    };

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_O_W-1:0] m_tdata;
    logic [2:0]           m_tuser;
    logic                 m_tlast;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [2:0]           paddr    = '0;
    logic [31:0]          pwdata   = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // line model state
    logic [7:0]   line_buf [LINE_MAX];
    logic [6:0]   line_len    = '0;
    logic [1:0]   open_cont   = '0;
    logic         line_bad    = 1'b0;
    logic         line_lost   = 1'b0;
    logic         fallback_on = 1'b1;

    char_result_t pending_chars [$];
    char_result_t step_chars [$];
    logic [7:0]   line_bytes [$];

    logic no_idle   = 1'b0;
    int   idle_odds = 3;
    int   stall_left;
    int   errors    = 0;
    int   checked   = 0;
    int   n_fb      = 0;
    int   n_err     = 0;
    int   n_ovf     = 0;
    int   items_sent = 0;
    int   lines_sent = 0;
    int   stuck_cycles = 0;

    utf8_check_cp437_fallback uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string what, input int idx, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("ERROR %s (#%0d): got 0x%0h, want 0x%0h", what, idx, got, want);
        errors++;
    endtask

    function automatic logic [34:0] cp437_to_utf8(input logic [7:0] b);
        logic [15:0] cp;
        cp = CP437_UNI[b];
        if (cp < 16'h0080)
            return {3'd1, 16'h0000, cp};
        if (cp < 16'h0800)
            return {3'd2, 16'h0000, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        return {3'd3, 8'h00, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
    endfunction

    // advances the line model by one input transfer; results land in step_chars
    task automatic model_line_item(input logic [7:0] b, input logic present, input logic last);
        logic [34:0] enc;
        int          i;
        step_chars.delete();
        if (present)
        begin
            if (line_len < LINE_MAX)
            begin
                line_buf[line_len] = b;
                line_len++;
                if (!line_bad)
                begin
                    if (open_cont != 0)
                    begin
                        if (b[7:6] == 2'b10)
                            open_cont--;
                        else
                            line_bad = 1'b1;
                    end
                    else if (b[7:5] == 3'b110)
                        open_cont = 2'd1;
                    else if (b[7:4] == 4'b1110)
                        open_cont = 2'd2;
                    else if (b[7:3] == 5'b11110)
                        open_cont = 2'd3;
                    else if (b[7])
                        line_bad = 1'b1;
                end
            end
            else
                line_lost = 1'b1;
        end
        if (last)
        begin
            if (open_cont != 0)
                line_bad = 1'b1;
            lines_sent++;
            if (line_len == 0)
                step_chars.insert(step_chars.size(),
                                  '{32'h0, 3'd0, 1'b0, 1'b0, line_lost, 1'b1});
            else if (!line_bad)
            begin
                for (i = 0; i < line_len; i++)
                    step_chars.insert(step_chars.size(),
                                      '{{24'h0, line_buf[i]}, 3'd1, 1'b0, 1'b0, line_lost,
                                        i == line_len - 1});
            end
            else if (fallback_on)
            begin
                for (i = 0; i < line_len; i++)
                begin
                    enc = cp437_to_utf8(line_buf[i]);
                    step_chars.insert(step_chars.size(),
                                      '{enc[31:0], enc[34:32], 1'b1, 1'b0, line_lost,
                                        i == line_len - 1});
                end
            end
            else
                step_chars.insert(step_chars.size(),
                                  '{32'h0, 3'd0, 1'b0, 1'b1, line_lost, 1'b1});
            line_len  = '0;
            open_cont = '0;
            line_bad  = 1'b0;
            line_lost = 1'b0;
        end
    endtask

    task automatic send_item(input logic [7:0] b, input logic present, input logic last,
                             input logic keep);
        if (!no_idle && $urandom_range(0, idle_odds) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= present;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        model_line_item(b, present, last);
        if (keep)
            foreach (step_chars[i])
                pending_chars.insert(pending_chars.size(), step_chars[i]);
    endtask

    task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic read_fallback(input logic want);
        logic [31:0] rd;
        apb_xfer(1'b0, ADDR_ALLOW_FALLBACK, 32'h0, rd);
        if (rd != {31'h0, want})
            flag_mismatch("allow_fallback readback", 0, rd, {31'h0, want});
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_fallback(input logic v);
        logic [31:0] rd;
        wait_idle();
        apb_xfer(1'b1, ADDR_ALLOW_FALLBACK, {31'h0, v}, rd);
        fallback_on = v;
        read_fallback(v);
    endtask

    task automatic add_utf8_char();
        int cls;
        cls = $urandom_range(0, 5);
        if (cls < 3)
            line_bytes.insert(line_bytes.size(), 8'($urandom_range(8'h00, 8'h7F)));
        else
        begin
            case (cls)
                3:       line_bytes.insert(line_bytes.size(), 8'($urandom_range(8'hC0, 8'hDF)));
                4:       line_bytes.insert(line_bytes.size(), 8'($urandom_range(8'hE0, 8'hEF)));
                default: line_bytes.insert(line_bytes.size(), 8'($urandom_range(8'hF0, 8'hF7)));
            endcase
            repeat (cls - 2)
                line_bytes.insert(line_bytes.size(), 8'($urandom_range(8'h80, 8'hBF)));
        end
    endtask

    // first line of each pass overflows the buffer
    task automatic run_lines(input int target, input logic long_noise, input int tail);
        int   done;
        int   pick;
        int   need;
        int   n;
        logic on_byte;
        logic first;
        done  = 0;
        first = 1'b1;
        while (done < target)
        begin
            no_idle   = (done >= target - tail);
            idle_odds = $urandom_range(0, 1) ? 3 : 15;
            line_bytes.delete();
            if (first)
            begin
                n = $urandom_range(LINE_MAX + 1, LINE_MAX + 4);
                while (line_bytes.size() < n)
                begin
                    if (long_noise)
                        line_bytes.insert(line_bytes.size(), 8'($urandom_range(0, 255)));
                    else
                        add_utf8_char();
                end
                first = 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 19);
                if (pick < 10)
                    repeat ($urandom_range(0, 6)) add_utf8_char();
                else if (pick < 13)
                begin
                    // sequence left open at the line end
                    repeat ($urandom_range(0, 4)) add_utf8_char();
                    need = $urandom_range(1, 3);
                    case (need)
                        1:
                            line_bytes.insert(line_bytes.size(),
                                              8'($urandom_range(8'hC0, 8'hDF)));
                        2:
                            line_bytes.insert(line_bytes.size(),
                                              8'($urandom_range(8'hE0, 8'hEF)));
                        default:
                            line_bytes.insert(line_bytes.size(),
                                              8'($urandom_range(8'hF0, 8'hF7)));
                    endcase
                    repeat ($urandom_range(0, need - 1))
                        line_bytes.insert(line_bytes.size(), 8'($urandom_range(8'h80, 8'hBF)));
                end
                else if (pick < 17)
                    repeat ($urandom_range(1, 8))
                        line_bytes.insert(line_bytes.size(), 8'($urandom_range(0, 255)));
                else
                begin
                    repeat ($urandom_range(1, 5)) add_utf8_char();
                    line_bytes[$urandom_range(0, line_bytes.size() - 1)] =
                        8'($urandom_range(0, 255));
                end
            end
            on_byte = (line_bytes.size() != 0) && ($urandom_range(0, 1) == 1);
            for (int k = 0; k < line_bytes.size(); k++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
                send_item(line_bytes[k], 1'b1, on_byte && (k == line_bytes.size() - 1), 1'b1);
            end
            if (!on_byte)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b1);
            done += line_bytes.size() + (on_byte ? 0 : 1);
        end
    endtask

    // receiver: stalls and checks
    always @(posedge clk)
    begin : rx_side
        char_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_chars.size() == 0)
                    flag_mismatch("result with none expected", checked, m_tdata[31:0], 32'h0);
                else
                begin
                    want = pending_chars.pop_front();
                    if (m_tdata[31:0] != want.bytes)
                        flag_mismatch("char_bytes", checked, m_tdata[31:0], want.bytes);
                    if (m_tdata[34:32] != want.len)
                        flag_mismatch("char_len", checked, 32'(m_tdata[34:32]),
                                      32'(want.len));
                    if (m_tuser[0] != want.fb)
                        flag_mismatch("fallback_used", checked, 32'(m_tuser[0]),
                                      32'(want.fb));
                    if (m_tuser[1] != want.err)
                        flag_mismatch("line_error", checked, 32'(m_tuser[1]),
                                      32'(want.err));
                    if (m_tuser[2] != want.ovf)
                        flag_mismatch("line_overflow", checked, 32'(m_tuser[2]),
                                      32'(want.ovf));
                    if (m_tlast != want.last)
                        flag_mismatch("last_of_line", checked, 32'(m_tlast), 32'(want.last));
                    n_fb  += want.fb;
                    n_err += want.err;
                    n_ovf += want.ovf;
                end
                checked++;
            end
            if (stall_left != 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= stall_left - 1;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                m_tready   <= 1'b0;
                stall_left <= $urandom_range(0, 5);
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     STUCK_LIMIT, pending_chars.size());
            $display("** utf8_check_cp437_fallback: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;
        stall_left = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        read_fallback(1'b1);

        for (int r = 0; r < 24; r++)
        begin
            row = DIRECTED[r];
            if (row.kind == ROW_WRITE)
                write_fallback(row.data[0]);
            else
            begin
                send_item(row.data, row.present, row.last, !row.typed);
                if (row.typed)
                    pending_chars.insert(pending_chars.size(),
                                         '{row.w_bytes, row.w_len, row.w_fb, row.w_err,
                                           1'b0, 1'b1});
            end
        end

        run_lines(66, 1'b1, 0);
        write_fallback(1'b1);
        run_lines(74, 1'b0, 12);
        wait_idle();

        $display("Sent %0d input transfers over %0d lines, fallback off and on, overflow included.",
                 items_sent, lines_sent);
        $display("Checked %0d results: %0d transcoded, %0d error, %0d on overflowed lines.",
                 checked, n_fb, n_err, n_ovf);
        if (errors == 0)
            $display("** utf8_check_cp437_fallback: PASSED **");
        else
            $display("** utf8_check_cp437_fallback: FAILED **");
        $finish;
    end

endmodule
